@@ rtl/fairrw_pkg.sv @@
// ----------------------------------------------------------------------------
// fairrw_pkg
// Shared types, codes and constants of the fair reader-writer lock unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fairrw_pkg;

   // Field widths fixed by the request and response formats
   localparam int MODE_W     = 3;
   localparam int REQ_ID_W   = 4;
   localparam int KIND_W     = 2;
   localparam int OUT_CNT_W  = 8;
   localparam int WR_CNT_W   = 5;
   localparam int ENTRY_W    = 6;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   // Requester ids at or above this value are refused
   localparam int REQUESTERS = 16;

   // Defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int COUNT_MAX_DEF   = 255;

   // Most writers that may wait at once
   localparam logic [WR_CNT_W-1:0] WRITERS_MAX = 5'd31;

   // Waiter entry layout: batch marker, costly flag, writer id
   localparam int ENTRY_BATCH_BIT  = 5;
   localparam int ENTRY_COSTLY_BIT = 4;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_WR_LOCK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_TRY    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RD_LOCK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RD_TRY    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RD_UNLOCK = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WR_UNLOCK = 3'd5;

   // Waiter grant kinds
   localparam logic [KIND_W-1:0] GRANT_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] GRANT_WRITER = 2'd1;
   localparam logic [KIND_W-1:0] GRANT_BATCH  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [REQ_ID_W-1:0] requester;
      logic                expensive;
   } req_type;

   typedef struct packed {
      logic                 granted_now;
      logic                 queued;
      logic [KIND_W-1:0]    grant_kind;
      logic [REQ_ID_W-1:0]  grant_writer;
      logic [OUT_CNT_W-1:0] grant_reader_count;
      logic [OUT_CNT_W-1:0] reader_count;
      logic                 writer_held;
      logic [OUT_CNT_W-1:0] waiting_readers;
      logic [WR_CNT_W-1:0]  waiting_writers;
      logic                 read_would_be_costly;
      logic                 write_would_be_costly;
      logic                 error;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/fairrw_ram.sv @@
// ----------------------------------------------------------------------------
// fairrw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fairrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/fairrw_core.sv @@
// ----------------------------------------------------------------------------
// fairrw_core
// Lock state, waiter queue pointers and the per-request decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module fairrw_core
   import fairrw_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int COUNT_MAX   = COUNT_MAX_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire req_type                        item,
   output rsp_type                             result,
   output logic                                ram_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_wr_addr,
   output logic [ENTRY_W-1:0]                  ram_wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_rd_addr,
   input  wire logic [ENTRY_W-1:0]             ram_rd_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W  = $clog2(COUNT_MAX + 1);

   localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(COUNT_MAX);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   // Wrap-around pointer advance
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W+1)'(1);
      ptr_next = (s >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : s[PTR_W-1:0];
   endfunction

   // Counter to the 8-bit report width
   function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CNT_W-1:0] x);
      logic [CNT_W+OUT_CNT_W-1:0] w;
      w = {{OUT_CNT_W{1'b0}}, x};
      to_out = w[OUT_CNT_W-1:0];
   endfunction

   // State
   logic [CNT_W-1:0]    hold_rd_ff, hold_rd_in;
   logic                writer_ff, writer_in;
   logic                hold_exp_ff, hold_exp_in;
   logic [CNT_W-1:0]    blk_rd_ff, blk_rd_in;
   logic [WR_CNT_W-1:0] blk_wr_ff, blk_wr_in;
   logic [WR_CNT_W-1:0] blk_cw_ff, blk_cw_in;
   logic                batch_ff, batch_in;
   logic                batch_cost_ff, batch_cost_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                byp_ff, byp_in;
   logic [ENTRY_W-1:0]  byp_data_ff;

   // Working signals
   logic [ENTRY_W-1:0]  head_entry;
   logic                full;
   logic                push, pop;
   logic [ENTRY_W-1:0]  push_data;
   logic [WR_CNT_W-1:0] wg_blk_wr, wg_blk_cw;
   logic                granted, queued, err;
   logic [KIND_W-1:0]   kind;
   logic [REQ_ID_W-1:0] gw;
   logic [CNT_W-1:0]    grc;
   logic                wcost;

   // Head entry: the bypass covers a write to the head address in the previous cycle
   assign head_entry = byp_ff ? byp_data_ff : ram_rd_data;
   assign full       = (fill_ff == FILL_FULL);

   // Counts after handing the lock to the head writer
   assign wg_blk_wr = (blk_wr_ff != '0) ? blk_wr_ff - WR_CNT_W'(1) : blk_wr_ff;
   assign wg_blk_cw = (head_entry[ENTRY_COSTLY_BIT] && blk_cw_ff != '0)
                      ? blk_cw_ff - WR_CNT_W'(1) : blk_cw_ff;

   // Request decision
   always_comb begin
      hold_rd_in    = hold_rd_ff;
      writer_in     = writer_ff;
      hold_exp_in   = hold_exp_ff;
      blk_rd_in     = blk_rd_ff;
      blk_wr_in     = blk_wr_ff;
      blk_cw_in     = blk_cw_ff;
      batch_in      = batch_ff;
      batch_cost_in = batch_cost_ff;
      push          = 1'b0;
      pop           = 1'b0;
      push_data     = '0;
      granted       = 1'b0;
      queued        = 1'b0;
      err           = 1'b0;
      kind          = GRANT_NONE;
      gw            = '0;
      grc           = '0;

      if (fire) begin
         if ({28'd0, item.requester} >= 32'(REQUESTERS)) begin
            err = 1'b1;
         end else begin
            unique case (item.mode) inside
               MODE_WR_LOCK, MODE_WR_TRY: begin
                  if (hold_rd_ff != '0 || writer_ff || blk_wr_ff != '0) begin
                     if (item.mode == MODE_WR_LOCK) begin
                        if (full || blk_wr_ff >= WRITERS_MAX) begin
                           err = 1'b1;
                        end else begin
                           push      = 1'b1;
                           push_data = {1'b0, item.expensive, item.requester};
                           blk_wr_in = blk_wr_ff + WR_CNT_W'(1);
                           if (item.expensive) begin
                              blk_cw_in = blk_cw_ff + WR_CNT_W'(1);
                           end
                           queued = 1'b1;
                        end
                     end
                  end else begin
                     writer_in   = 1'b1;
                     hold_exp_in = item.expensive;
                     granted     = 1'b1;
                  end
               end
               MODE_RD_LOCK, MODE_RD_TRY: begin
                  if (writer_ff || blk_wr_ff != '0) begin
                     if (item.mode == MODE_RD_LOCK) begin
                        if (blk_rd_ff >= CNT_LIMIT || (!batch_ff && full)) begin
                           err = 1'b1;
                        end else begin
                           if (!batch_ff) begin
                              push          = 1'b1;
                              push_data     = '0;
                              push_data[ENTRY_BATCH_BIT] = 1'b1;
                              batch_in      = 1'b1;
                              batch_cost_in = hold_exp_ff || (blk_cw_ff != '0);
                           end
                           blk_rd_in = blk_rd_ff + CNT_W'(1);
                           queued    = 1'b1;
                        end
                     end
                  end else if (hold_rd_ff >= CNT_LIMIT) begin
                     err = 1'b1;
                  end else begin
                     hold_rd_in = hold_rd_ff + CNT_W'(1);
                     granted    = 1'b1;
                  end
               end
               MODE_RD_UNLOCK: begin
                  if (writer_ff || hold_rd_ff == '0) begin
                     err = 1'b1;
                  end else begin
                     hold_rd_in = hold_rd_ff - CNT_W'(1);
                     // last reader out hands over to a waiting head writer
                     if (hold_rd_ff == CNT_W'(1) && blk_wr_ff != '0 && fill_ff != '0 &&
                         !head_entry[ENTRY_BATCH_BIT]) begin
                        pop         = 1'b1;
                        writer_in   = 1'b1;
                        hold_exp_in = head_entry[ENTRY_COSTLY_BIT];
                        blk_wr_in   = wg_blk_wr;
                        blk_cw_in   = wg_blk_cw;
                        gw          = head_entry[REQ_ID_W-1:0];
                        kind        = GRANT_WRITER;
                     end
                  end
               end
               MODE_WR_UNLOCK: begin
                  if (!writer_ff) begin
                     err = 1'b1;
                  end else begin
                     writer_in   = 1'b0;
                     hold_exp_in = 1'b0;
                     if (fill_ff != '0) begin
                        pop = 1'b1;
                        if (head_entry[ENTRY_BATCH_BIT]) begin
                           grc           = blk_rd_ff;
                           hold_rd_in    = hold_rd_ff + blk_rd_ff;
                           blk_rd_in     = '0;
                           batch_in      = 1'b0;
                           batch_cost_in = 1'b0;
                           kind          = GRANT_BATCH;
                        end else begin
                           writer_in   = 1'b1;
                           hold_exp_in = head_entry[ENTRY_COSTLY_BIT];
                           blk_wr_in   = wg_blk_wr;
                           blk_cw_in   = wg_blk_cw;
                           gw          = head_entry[REQ_ID_W-1:0];
                           kind        = GRANT_WRITER;
                        end
                     end
                  end
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
      end
   end

   // Queue pointers
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = ptr_next(tail_ff);
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop) begin
         head_in = ptr_next(head_ff);
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   // RAM access: write at tail, keep reading the next head
   assign ram_wr_en   = push;
   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = push_data;
   assign ram_rd_addr = head_in;
   assign byp_in      = push && (tail_ff == head_in);

   // Result fields from the updated state
   assign wcost = hold_exp_in || (blk_cw_in != '0);

   always_comb begin
      result.granted_now           = granted;
      result.queued                = queued;
      result.grant_kind            = kind;
      result.grant_writer          = gw;
      result.grant_reader_count    = to_out(grc);
      result.reader_count          = to_out(hold_rd_in);
      result.writer_held           = writer_in;
      result.waiting_readers       = to_out(blk_rd_in);
      result.waiting_writers       = blk_wr_in;
      result.read_would_be_costly  = batch_in ? batch_cost_in : wcost;
      result.write_would_be_costly = wcost;
      result.error                 = err;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_rd_ff    <= '0;
         writer_ff     <= 1'b0;
         hold_exp_ff   <= 1'b0;
         blk_rd_ff     <= '0;
         blk_wr_ff     <= '0;
         blk_cw_ff     <= '0;
         batch_ff      <= 1'b0;
         batch_cost_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         byp_ff        <= 1'b0;
      end else begin
         hold_rd_ff    <= hold_rd_in;
         writer_ff     <= writer_in;
         hold_exp_ff   <= hold_exp_in;
         blk_rd_ff     <= blk_rd_in;
         blk_wr_ff     <= blk_wr_in;
         blk_cw_ff     <= blk_cw_in;
         batch_ff      <= batch_in;
         batch_cost_ff <= batch_cost_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         byp_ff        <= byp_in;
      end
   end

   // Bypass data
   always_ff @(posedge clock) begin
      byp_data_ff <= push_data;
   end

endmodule

`default_nettype wire

@@ rtl/fair_reader_writer_lock_unit.sv @@
// ----------------------------------------------------------------------------
// fair_reader_writer_lock_unit
// Reader-writer lock arbiter with a FIFO of waiting writers and reader batches.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries lock, try-lock and unlock requests (mode, requester id,
//   expensive flag). rsp_* returns exactly one item per request: immediate
//   grant, queued flag, any waiter grant made, the counts after the request,
//   the two cost hints and an error flag for refused requests.
//   A request is registered on acceptance and its response is registered
//   when the core takes it, which waits while a stalled response holds the
//   output register. One request per cycle is sustained while rsp_tready
//   is high; each request touches only counters and one end of the waiter
//   queue, which lives in a RAM whose head entry is read ahead so a release
//   can grant the head in the same cycle.
//   When rsp_tready is low the response register holds, the input register
//   keeps the next request and req_tready drops once both are occupied.
//   Reset clears all counters and empties the queue at once; no clearing
//   pass is needed since only filled queue entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module fair_reader_writer_lock_unit
   import fairrw_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int COUNT_MAX   = COUNT_MAX_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [2:0] mode, [6:3] requester, [7] expensive
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] granted_now, [1] queued, [3:2] grant_kind, [7:4] grant_writer,
   // [15:8] grant_reader_count, [23:16] reader_count, [24] writer_held,
   // [32:25] waiting_readers, [37:33] waiting_writers,
   // [38] read_would_be_costly, [39] write_would_be_costly, [40] error,
   // [47:41] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;
   logic                fire;
   logic                req_accept;
   rsp_type             result;
   logic                ram_wr_en;
   logic [PTR_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [PTR_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   // Handshake
   assign fire        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input and response payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.mode      <= req_tdata[2:0];
         in_item_ff.requester <= req_tdata[6:3];
         in_item_ff.expensive <= req_tdata[7];
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   fairrw_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COUNT_MAX   (COUNT_MAX)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_item_ff),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Waiter queue storage
   fairrw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_data_ff.error,
                        out_data_ff.write_would_be_costly,
                        out_data_ff.read_would_be_costly,
                        out_data_ff.waiting_writers,
                        out_data_ff.waiting_readers,
                        out_data_ff.writer_held,
                        out_data_ff.reader_count,
                        out_data_ff.grant_reader_count,
                        out_data_ff.grant_writer,
                        out_data_ff.grant_kind,
                        out_data_ff.queued,
                        out_data_ff.granted_now};

endmodule

`default_nettype wire

@@ rtl/fairrw_checker.sv @@
// ----------------------------------------------------------------------------
// fairrw_checker
// Port-level checks on the response stream of the lock unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fairrw_checker
   import fairrw_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A refused request grants and queues nothing
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |->
         !rsp_tdata[0] && !rsp_tdata[1] && rsp_tdata[3:2] == GRANT_NONE)
      else $error("refused request changed the lock");

   // Readers and a writer never hold together
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[24] && rsp_tdata[23:16] != 8'd0))
      else $error("readers and writer both hold the lock");

   // A writer grant leaves a writer holding
   a_writer_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:2] == GRANT_WRITER |-> rsp_tdata[24])
      else $error("writer grant without writer holding");

endmodule

bind fair_reader_writer_lock_unit fairrw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
